[src/srmmv_pkg.sv]
`timescale 1ns / 1ps

package srmmv_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StAccum,
    StFinSum,
    StFinScale,
    StFinDivisor,
    StDivide,
    StDone
  } state_e;

endpackage

[src/sample_run_min_max_variance.sv]
`timescale 1ns / 1ps

// Run statistics over unsigned 32-bit timing samples. Each sample arrives as one item on
// the slave stream, and the item with tlast high closes the run. For the run the block keeps a
// wrapping sum, a wrapping sum of squares, the count and the minimum and maximum. On the closing
// item it sends one result item with the minimum, the maximum, their spread and the modular
// variance ((n*sumsq) - sum*sum) / (n*n), all taken mod 2^32. Then all accumulators clear.
// Samples past MAX_SAMPLES in one run are dropped and flagged in tuser. All products are made
// by one shared 32x32 multiplier, and the quotient by a restoring divider that finds one bit
// per cycle. Each sample goes through accept, square and accumulate steps. The closing sample
// then takes 3 multiplier steps and 32 divider steps before the output register is loaded,
// after any wait for the previous result to be taken. New samples are accepted while
// a finished result still waits in the output register.
module sample_run_min_max_variance #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // sample
  input  logic         s_axis_tlast_i,   // last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // min_value, max_value, spread, variance
  output logic         m_axis_tuser_o    // too_many
);

  localparam int unsigned DW   = srmmv_pkg::DataW;
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DivCntW = $clog2(DW);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DW - 1);

  srmmv_pkg::state_e state_q, state_d;

  logic [DW-1:0]      sample_q;
  logic               last_q;
  logic [DW-1:0]      prod_q;
  logic [DW-1:0]      sum_q, sumsq_q, min_q, max_q;
  logic [CntW-1:0]    cnt_q;
  logic               overrun_q;
  logic [DW-1:0]      sq_q;
  logic [DW-1:0]      divisor_q;
  logic [DW-1:0]      quot_q, rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               out_valid_q;
  logic [127:0]       out_data_q;
  logic               out_user_q;

  logic [DW-1:0] mul_a, mul_b, mul_p;
  logic [DW-1:0] cnt_ext;
  logic [DW:0]   trial;
  logic          in_acc, out_free, cnt_full;

  assign cnt_ext  = {{(DW - CntW){1'b0}}, cnt_q};
  assign cnt_full = (cnt_q == CntMax);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign mul_p    = DW'(mul_a * mul_b);
  // restoring step: shift in the next dividend bit, try the subtract
  assign trial    = {rem_q, quot_q[DW-1]} - {1'b0, divisor_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      srmmv_pkg::StIdle:       if (in_acc) state_d = srmmv_pkg::StSquare;
      srmmv_pkg::StSquare:     state_d = srmmv_pkg::StAccum;
      srmmv_pkg::StAccum:      state_d = last_q ? srmmv_pkg::StFinSum : srmmv_pkg::StIdle;
      srmmv_pkg::StFinSum:     state_d = srmmv_pkg::StFinScale;
      srmmv_pkg::StFinScale:   state_d = srmmv_pkg::StFinDivisor;
      srmmv_pkg::StFinDivisor: state_d = srmmv_pkg::StDivide;
      srmmv_pkg::StDivide:     if (div_cnt_q == DivLast) state_d = srmmv_pkg::StDone;
      srmmv_pkg::StDone:       if (out_free) state_d = srmmv_pkg::StIdle;
      default:                 state_d = srmmv_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_a           = sample_q;
    mul_b           = sample_q;
    case (state_q)
      srmmv_pkg::StIdle:       s_axis_tready_o = 1'b1;
      srmmv_pkg::StFinSum: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      srmmv_pkg::StFinScale: begin
        mul_a = sumsq_q;
        mul_b = cnt_ext;
      end
      srmmv_pkg::StFinDivisor: begin
        mul_a = cnt_ext;
        mul_b = cnt_ext;
      end
      default: begin
        mul_a = sample_q;
        mul_b = sample_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srmmv_pkg::StIdle;
      sum_q       <= '0;
      sumsq_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      overrun_q   <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == srmmv_pkg::StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        srmmv_pkg::StAccum: begin
          if (cnt_full) begin
            overrun_q <= 1'b1;
          end else begin
            if (cnt_q == '0 || sample_q < min_q) min_q <= sample_q;
            if (cnt_q == '0 || sample_q > max_q) max_q <= sample_q;
            sum_q   <= sum_q + sample_q;
            sumsq_q <= sumsq_q + prod_q;
            cnt_q   <= cnt_q + 1'b1;
          end
        end
        srmmv_pkg::StFinDivisor: div_cnt_q <= '0;
        srmmv_pkg::StDivide:     div_cnt_q <= div_cnt_q + 1'b1;
        srmmv_pkg::StDone: begin
          if (out_free) begin
            sum_q       <= '0;
            sumsq_q     <= '0;
            min_q       <= '0;
            max_q       <= '0;
            cnt_q       <= '0;
            overrun_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata_i;
      last_q   <= s_axis_tlast_i;
    end
    case (state_q)
      srmmv_pkg::StSquare:     prod_q <= mul_p;
      srmmv_pkg::StFinSum:     sq_q <= mul_p;
      srmmv_pkg::StFinScale: begin
        quot_q <= mul_p - sq_q;
        rem_q  <= '0;
      end
      srmmv_pkg::StFinDivisor: divisor_q <= mul_p;
      srmmv_pkg::StDivide: begin
        if (!trial[DW]) begin
          rem_q  <= trial[DW-1:0];
          quot_q <= {quot_q[DW-2:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[DW-2:0], quot_q[DW-1]};
          quot_q <= {quot_q[DW-2:0], 1'b0};
        end
      end
      srmmv_pkg::StDone: begin
        if (out_free) begin
          out_data_q <= {(divisor_q == '0) ? {DW{1'b0}} : quot_q, max_q - min_q, max_q, min_q};
          out_user_q <= overrun_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // overrun only once the count is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) overrun_q |-> cnt_full)
    else $error("overrun flag set with count below maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == srmmv_pkg::StSquare))
    else $error("accepted item did not start the square step");

  // a new result is loaded only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != srmmv_pkg::StDone) |=> !$rose(out_valid_q))
    else $error("result loaded outside the done state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srmmv_pkg::StDone && out_free) |=> (cnt_q == '0 && !overrun_q))
    else $error("accumulators not cleared after result");

endmodule

[tb/tb_sample_run_min_max_variance.sv]
`timescale 1ns / 1ps

module tb_sample_run_min_max_variance;

  localparam int unsigned MaxSamples    = 4096;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TailCycles    = 60;
  localparam int unsigned CycleLimit    = 3000000;
  localparam int unsigned RandomItems   = 1450;

  typedef struct packed {
    logic [srmmv_pkg::DataW-1:0] min_value;
    logic [srmmv_pkg::DataW-1:0] max_value;
    logic [srmmv_pkg::DataW-1:0] spread;
    logic [srmmv_pkg::DataW-1:0] variance;
    logic                        too_many;
  } run_stats_t;

  logic         clk_i;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i  = '0;  // sample
  logic         s_axis_tlast_i  = 1'b0; // last
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;        // min_value, max_value, spread, variance
  logic         m_axis_tuser_o;        // too_many

  // predictor state for the open run
  logic [srmmv_pkg::DataW-1:0] run_sum    = '0;
  logic [srmmv_pkg::DataW-1:0] run_sqsum  = '0;
  logic [srmmv_pkg::DataW-1:0] run_count  = '0;
  logic [srmmv_pkg::DataW-1:0] run_min    = '0;
  logic [srmmv_pkg::DataW-1:0] run_max    = '0;
  logic                        run_overrun = 1'b0;

  run_stats_t  pending_stats[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  bit          gaps_enabled   = 1'b1;
  logic        hold_off_req   = 1'b0;
  logic        hold_off_done  = 1'b0;

  sample_run_min_max_variance #(
    .MAX_SAMPLES(MaxSamples)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void accumulate_sample(logic [srmmv_pkg::DataW-1:0] value, logic fin);
    run_stats_t                  stats;
    logic [srmmv_pkg::DataW-1:0] sq_of_sum;
    logic [srmmv_pkg::DataW-1:0] scaled;
    logic [srmmv_pkg::DataW-1:0] divisor;
    if (run_count >= MaxSamples) begin
      run_overrun = 1'b1;
    end else begin
      if (run_count == 0) begin
        run_min = value;
        run_max = value;
      end else begin
        if (value < run_min) run_min = value;
        if (value > run_max) run_max = value;
      end
      run_sum   += value;
      run_sqsum += value * value;
      run_count++;
    end
    if (fin) begin
      sq_of_sum = run_sum * run_sum;
      scaled    = run_sqsum * run_count;
      divisor   = run_count * run_count;
      stats.min_value = run_min;
      stats.max_value = run_max;
      stats.spread    = run_max - run_min;
      stats.variance  = (divisor == 0) ? '0 : (scaled - sq_of_sum) / divisor;
      stats.too_many  = run_overrun;
      pending_stats.push_back(stats);
      run_sum     = '0;
      run_sqsum   = '0;
      run_count   = '0;
      run_min     = '0;
      run_max     = '0;
      run_overrun = 1'b0;
    end
  endfunction

  function automatic logic [31:0] pick_sample(logic [31:0] base);
    logic [31:0] value;
    case ($urandom_range(0, 5))
      0: begin
        value = $urandom();
      end
      1: begin
        value = $urandom_range(0, 255);
      end
      2: begin
        value = 32'hFFFF_FFFF - $urandom_range(0, 255);
      end
      3: begin
        value = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        // timing-like jitter around a per-run base
        value = base + $urandom_range(0, 63);
      end
    endcase
    return value;
  endfunction

  task automatic send_sample(input logic [31:0] value, input logic fin);
    int unsigned gap;
    if (gaps_enabled && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    accumulate_sample(value, fin);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    run_stats_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %h / %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("min_value", want.min_value, m_axis_tdata_o[31:0]);
        check_field("max_value", want.max_value, m_axis_tdata_o[63:32]);
        check_field("spread", want.spread, m_axis_tdata_o[95:64]);
        check_field("variance", want.variance, m_axis_tdata_o[127:96]);
        check_field("too_many", {31'b0, want.too_many}, {31'b0, m_axis_tuser_o});
      end
    end
  end

  // receiver: random stall modes, plus a long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned held;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready_i <= 1'b0;
        for (held = 1; held < HoldOffCycles; held++) @(negedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: begin
            m_axis_tready_i <= 1'b1;
          end
          1: begin
            m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            m_axis_tready_i <= ($urandom_range(0, 4) == 0);
          end
        endcase
      end
    end
  end

  task automatic test_directed_cases();
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    // zero as first sample must still be the minimum
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_000A, 1'b0);
    send_sample(32'h0000_0014, 1'b1);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0003, 1'b0);
    send_sample(32'h0000_0009, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0007, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0007, 1'b0);
    send_sample(32'h0000_0007, 1'b0);
    send_sample(32'h0000_0007, 1'b1);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h5555_5555, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
  endtask

  task automatic test_random_runs();
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    logic [31:0] base;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) run_len = $urandom_range(1, 8);
      else if (pick < 95) run_len = $urandom_range(9, 40);
      else run_len = $urandom_range(41, 200);
      gaps_enabled = ($urandom_range(0, 4) != 0);
      base = $urandom();
      for (int unsigned i = 0; i < run_len; i++) begin
        send_sample(pick_sample(base), i == run_len - 1);
      end
      sent += run_len;
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_output_hold_off();
    gaps_enabled = 1'b0;
    hold_off_req = 1'b1;
    // short runs keep closing while the result side is blocked
    while (!hold_off_done) begin
      send_sample($urandom(), 1'b0);
      send_sample($urandom(), 1'b1);
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int unsigned i = 0; i < 12; i++) begin
      send_sample($urandom_range(1000, 1100), (i % 4) == 3);
    end
    wait_results_drained();
    for (int unsigned i = 0; i < 6; i++) begin
      send_sample($urandom(), (i % 3) == 2);
    end
  endtask

  task automatic test_overlong_runs();
    logic [31:0] base;
    base = $urandom();
    wait_results_drained();
    // exactly full run, then a run three samples past full where the closing sample is dropped
    for (int unsigned i = 0; i < MaxSamples; i++) begin
      send_sample(pick_sample(base), i == MaxSamples - 1);
    end
    gaps_enabled = 1'b0;
    for (int unsigned i = 0; i < MaxSamples + 3; i++) begin
      send_sample(pick_sample(base), i == MaxSamples + 2);
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_runs();
    test_output_hold_off();
    test_drain_pause();
    test_overlong_runs();
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
